/* rtl/i2crm_pkg.sv */
// Package for the I2C register master: request and result payload types
// and bus constants. No dependencies; used by i2c_register_master_unit.
package i2crm_pkg;

	typedef struct packed {
		logic       start_request;
		logic       read_not_write;
		logic [6:0] device_id;
		logic [7:0] register_address;
		logic [7:0] byte_count;
		logic [7:0] write_byte;
		logic       sda_sample;
	} req_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_pull_low;
		logic       busy_res;
		logic [7:0] byte_position;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       done_res;
		logic       nack_error;
	} res_t;

	localparam logic [3:0] ACK_POLLS_RESET = 4'd2;
	localparam logic [3:0] POLL_MAX        = 4'd15;
	localparam logic [2:0] LAST_BIT        = 3'd7;

endpackage

/* rtl/i2c_register_master_unit.sv */
// I2C register master: tick-driven bit sequencer with a registered result.
// Depends on i2crm_pkg for the request and result payload types.
//
// Accepts one request per cycle while the result register is empty or being
// read; the sequencer state and the result register both update in the
// accepting cycle, and the registered result decouples the two sides.
// Reset clears the sequencer to idle, ack_polls to 2.
module i2c_register_master_unit
	import i2crm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req_data,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res_data,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_START, PH_TX_IDW, PH_ACK_IDW, PH_TX_REG, PH_ACK_REG,
		PH_TX_DAT, PH_ACK_DAT, PH_RESTART, PH_TX_IDR, PH_ACK_IDR, PH_RX,
		PH_MACK, PH_STOP_OK, PH_STOP_ERR
	} phase_t;

	phase_t     phase_q, n_phase;
	logic [1:0] tib_q, n_tib;
	logic [2:0] bitc_q, n_bitc;
	logic [7:0] shift_q, n_shift;
	logic [7:0] bytec_q, n_bytec;
	logic [3:0] poll_q, n_poll;
	logic       rd_q, n_rd;
	logic [6:0] id_q, n_id;
	logic [7:0] reg_q, n_reg;
	logic [7:0] cnt_q, n_cnt;
	logic [3:0] ack_polls_q;
	logic       res_valid_q;
	res_t       res_q, res_d;

	logic       accept;
	logic [7:0] sh;
	logic [7:0] cnt_eff;
	logic [3:0] limit;
	logic [3:0] poll_inc;
	logic       last;
	logic       tx_done;

	assign req_ready = !res_valid_q || res_ready;
	assign accept    = req_valid && req_ready;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign cnt_eff  = (cnt_q == 8'd0) ? 8'd1 : cnt_q;
	assign limit    = (ack_polls_q == 4'd0) ? 4'd1 : ack_polls_q;
	assign poll_inc = (poll_q < POLL_MAX) ? poll_q + 4'd1 : poll_q;
	assign last     = ({1'b0, bytec_q} + 9'd1) >= {1'b0, cnt_eff};
	// A written data byte is taken from the request on its first tick.
	assign sh = (phase_q == PH_TX_DAT && bitc_q == 3'd0 && tib_q == 2'd0) ?
		req_data.write_byte : shift_q;

	always_comb begin
		n_phase = phase_q;
		n_tib   = tib_q;
		n_bitc  = bitc_q;
		n_shift = shift_q;
		n_bytec = bytec_q;
		n_poll  = poll_q;
		n_rd    = rd_q;
		n_id    = id_q;
		n_reg   = reg_q;
		n_cnt   = cnt_q;
		tx_done = 1'b0;
		res_d = '0;
		res_d.scl_level = 1'b1;
		res_d.busy_res  = 1'b1;

		unique case (phase_q)
			PH_IDLE: begin
				res_d.busy_res = 1'b0;
				if (req_data.start_request) begin
					n_rd    = req_data.read_not_write;
					n_id    = req_data.device_id;
					n_reg   = req_data.register_address;
					n_cnt   = req_data.byte_count;
					n_bytec = 8'd0;
					n_poll  = 4'd0;
					n_tib   = 2'd0;
					n_bitc  = 3'd0;
					n_phase = PH_START;
					res_d.busy_res = 1'b1;
				end
			end
			PH_START: begin
				res_d.sda_pull_low = 1'b1;
				n_shift = {id_q, 1'b0};
				n_bitc  = 3'd0;
				n_tib   = 2'd0;
				n_phase = PH_TX_IDW;
			end
			PH_TX_IDW, PH_TX_REG, PH_TX_IDR, PH_TX_DAT: begin
				res_d.sda_pull_low = ~sh[7];
				n_shift = sh;
				unique case (tib_q)
					2'd0: begin
						res_d.scl_level = 1'b0;
						n_tib = 2'd1;
					end
					2'd1: begin
						n_tib = 2'd2;
					end
					default: begin
						res_d.scl_level = 1'b0;
						n_tib   = 2'd0;
						n_shift = {sh[6:0], 1'b0};
						if (bitc_q >= LAST_BIT) begin
							n_bitc  = 3'd0;
							tx_done = 1'b1;
						end else begin
							n_bitc = bitc_q + 3'd1;
						end
					end
				endcase
				if (tx_done) begin
					unique case (phase_q)
						PH_TX_IDW: n_phase = PH_ACK_IDW;
						PH_TX_REG: n_phase = PH_ACK_REG;
						PH_TX_IDR: n_phase = PH_ACK_IDR;
						default:   n_phase = PH_ACK_DAT;
					endcase
				end
			end
			PH_ACK_IDW, PH_ACK_REG, PH_ACK_DAT, PH_ACK_IDR: begin
				unique case (tib_q)
					2'd0: begin
						res_d.scl_level = 1'b0;
						if (!req_data.sda_sample) begin
							n_tib  = 2'd1;
							n_poll = 4'd0;
						end else if (poll_inc >= limit) begin
							n_poll  = 4'd0;
							n_tib   = 2'd0;
							n_phase = PH_STOP_ERR;
						end else begin
							n_poll = poll_inc;
						end
					end
					2'd1: begin
						n_tib = 2'd2;
					end
					default: begin
						res_d.scl_level = 1'b0;
						n_tib  = 2'd0;
						n_bitc = 3'd0;
						unique case (phase_q)
							PH_ACK_IDW: begin
								n_shift = reg_q;
								n_phase = PH_TX_REG;
							end
							PH_ACK_REG: begin
								n_bytec = 8'd0;
								n_bitc  = bitc_q;
								if (rd_q) begin
									n_phase = PH_RESTART;
								end else begin
									n_bitc  = 3'd0;
									n_shift = 8'd0;
									n_phase = PH_TX_DAT;
								end
							end
							PH_ACK_DAT: begin
								if (last) begin
									n_bitc  = bitc_q;
									n_phase = PH_STOP_OK;
								end else begin
									n_bytec = bytec_q + 8'd1;
									n_shift = 8'd0;
									n_phase = PH_TX_DAT;
								end
							end
							default: begin
								n_shift = 8'd0;
								n_phase = PH_RX;
							end
						endcase
					end
				endcase
			end
			PH_RESTART: begin
				unique case (tib_q)
					2'd0: begin
						res_d.scl_level = 1'b0;
						n_tib = 2'd1;
					end
					2'd1: begin
						n_tib = 2'd2;
					end
					default: begin
						res_d.sda_pull_low = 1'b1;
						n_shift = {id_q, 1'b1};
						n_bitc  = 3'd0;
						n_tib   = 2'd0;
						n_phase = PH_TX_IDR;
					end
				endcase
			end
			PH_RX: begin
				unique case (tib_q)
					2'd0: begin
						res_d.scl_level = 1'b0;
						n_tib = 2'd1;
					end
					2'd1: begin
						n_shift = {shift_q[6:0], req_data.sda_sample};
						n_tib   = 2'd2;
					end
					default: begin
						res_d.scl_level = 1'b0;
						n_tib = 2'd0;
						if (bitc_q >= LAST_BIT) begin
							n_bitc = 3'd0;
							res_d.read_byte  = shift_q;
							res_d.read_valid = 1'b1;
							n_phase = PH_MACK;
						end else begin
							n_bitc = bitc_q + 3'd1;
						end
					end
				endcase
			end
			PH_MACK: begin
				// The master acknowledges every byte but the last one.
				res_d.sda_pull_low = ~last;
				unique case (tib_q)
					2'd0: begin
						res_d.scl_level = 1'b0;
						n_tib = 2'd1;
					end
					2'd1: begin
						n_tib = 2'd2;
					end
					default: begin
						res_d.scl_level = 1'b0;
						n_tib = 2'd0;
						if (last) begin
							n_phase = PH_STOP_OK;
						end else begin
							n_bytec = bytec_q + 8'd1;
							n_shift = 8'd0;
							n_bitc  = 3'd0;
							n_phase = PH_RX;
						end
					end
				endcase
			end
			PH_STOP_OK, PH_STOP_ERR: begin
				unique case (tib_q)
					2'd0: begin
						res_d.scl_level    = 1'b0;
						res_d.sda_pull_low = 1'b1;
						n_tib = 2'd1;
					end
					2'd1: begin
						res_d.sda_pull_low = 1'b1;
						n_tib = 2'd2;
					end
					default: begin
						res_d.done_res   = 1'b1;
						res_d.nack_error = (phase_q == PH_STOP_ERR);
						n_tib   = 2'd0;
						n_phase = PH_IDLE;
					end
				endcase
			end
			default: begin
				res_d.busy_res = 1'b0;
				n_tib   = 2'd0;
				n_phase = PH_IDLE;
			end
		endcase
		res_d.byte_position = n_bytec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tib_q       <= 2'd0;
			bitc_q      <= 3'd0;
			shift_q     <= 8'd0;
			bytec_q     <= 8'd0;
			poll_q      <= 4'd0;
			rd_q        <= 1'b0;
			id_q        <= 7'd0;
			reg_q       <= 8'd0;
			cnt_q       <= 8'd0;
			ack_polls_q <= ACK_POLLS_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ack_polls_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q     <= n_phase;
				tib_q       <= n_tib;
				bitc_q      <= n_bitc;
				shift_q     <= n_shift;
				bytec_q     <= n_bytec;
				poll_q      <= n_poll;
				rd_q        <= n_rd;
				id_q        <= n_id;
				reg_q       <= n_reg;
				cnt_q       <= n_cnt;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	// The sequencer never uses the fourth tick code.
	a_tib_range: assert property (@(posedge clk) disable iff (!arst_n)
		tib_q != 2'd3)
		else $error("tick counter reached an unused code");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res |-> res_q.busy_res && phase_q == PH_IDLE)
		else $error("done reported outside the end of a transaction");

	a_nack_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.nack_error |-> res_q.done_res)
		else $error("nack flagged without done");

	a_rx_bus: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.read_valid |-> !res_q.scl_level && !res_q.sda_pull_low
			&& phase_q == PH_MACK)
		else $error("read byte delivered with the bus in the wrong state");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_IDLE && !req_data.start_request |=> !res_q.busy_res)
		else $error("idle request without start reported busy");

endmodule

/* verif/i2crm_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the I2C register master: predicts the result of every accepted
// request from its own copy of the bus sequencer and compares the result channel.
// Depends on i2crm_pkg for the payload types and bus constants.
module i2crm_checker
	import i2crm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_ready,
	input  req_t       req_data,
	input  logic       res_valid,
	input  logic       res_ready,
	input  res_t       res_data,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	output int         mismatch_count,
	output int         pending_count
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_START, ST_SEND_IDW, ST_ACK_IDW, ST_SEND_REG, ST_ACK_REG,
		ST_SEND_DATA, ST_ACK_DATA, ST_RESTART, ST_SEND_IDR, ST_ACK_IDR,
		ST_RECV, ST_MASTER_ACK, ST_STOP, ST_STOP_NACK
	} seq_state_e;

	typedef enum logic [1:0] {ACK_WAIT, ACK_SEEN, ACK_MISSING} ack_result_e;

	seq_state_e state;
	logic [1:0] tick;
	logic [3:0] bit_idx;
	logic [7:0] shreg;
	logic [7:0] byte_idx;
	logic [3:0] poll_cnt;
	logic       lat_read;
	logic [6:0] lat_id;
	logic [7:0] lat_reg;
	logic [7:0] lat_count;
	logic [3:0] polls_cfg;
	res_t       predicted_ticks[$];
	int         errors = 0;

	function automatic void load_shift(input logic [7:0] value);
		shreg = value;
		bit_idx = 4'd0;
		tick = 2'd0;
	endfunction

	// A byte count of zero moves one byte.
	function automatic logic last_byte();
		logic [8:0] total;
		total = (lat_count == 8'd0) ? 9'd1 : {1'b0, lat_count};
		return ({1'b0, byte_idx} + 9'd1) >= total;
	endfunction

	function automatic logic shift_out_tick(output logic scl, output logic pull);
		logic finished;
		finished = 1'b0;
		pull = ~shreg[7];
		if (tick == 2'd0) begin
			scl = 1'b0;
			tick = 2'd1;
		end else if (tick == 2'd1) begin
			scl = 1'b1;
			tick = 2'd2;
		end else begin
			scl = 1'b0;
			tick = 2'd0;
			shreg = {shreg[6:0], 1'b0};
			if (bit_idx >= LAST_BIT) begin
				bit_idx = 4'd0;
				finished = 1'b1;
			end else begin
				bit_idx++;
			end
		end
		return finished;
	endfunction

	function automatic res_t predict_bus_tick(input req_t rq);
		res_t        r;
		logic        scl, pull, busy, done, nack, rvalid;
		logic [7:0]  rbyte;
		logic [3:0]  limit;
		ack_result_e ack;
		scl = 1'b1;
		pull = 1'b0;
		busy = 1'b1;
		done = 1'b0;
		nack = 1'b0;
		rvalid = 1'b0;
		rbyte = 8'd0;
		ack = ACK_WAIT;
		case (state)
		ST_IDLE: begin
			busy = 1'b0;
			if (rq.start_request) begin
				lat_read = rq.read_not_write;
				lat_id = rq.device_id;
				lat_reg = rq.register_address;
				lat_count = rq.byte_count;
				byte_idx = 8'd0;
				poll_cnt = 4'd0;
				tick = 2'd0;
				bit_idx = 4'd0;
				busy = 1'b1;
				state = ST_START;
			end
		end
		ST_START: begin
			pull = 1'b1;
			load_shift({lat_id, 1'b0});
			state = ST_SEND_IDW;
		end
		ST_SEND_IDW: begin
			if (shift_out_tick(scl, pull)) state = ST_ACK_IDW;
		end
		ST_SEND_REG: begin
			if (shift_out_tick(scl, pull)) state = ST_ACK_REG;
		end
		ST_SEND_IDR: begin
			if (shift_out_tick(scl, pull)) state = ST_ACK_IDR;
		end
		ST_SEND_DATA: begin
			// The data byte is taken from the request on the first tick of its first bit.
			if (bit_idx == 4'd0 && tick == 2'd0) shreg = rq.write_byte;
			if (shift_out_tick(scl, pull)) state = ST_ACK_DATA;
		end
		ST_ACK_IDW, ST_ACK_REG, ST_ACK_DATA, ST_ACK_IDR: begin
			limit = (polls_cfg == 4'd0) ? 4'd1 : polls_cfg;
			if (tick == 2'd0) begin
				scl = 1'b0;
				if (!rq.sda_sample) begin
					tick = 2'd1;
					poll_cnt = 4'd0;
				end else begin
					if (poll_cnt < POLL_MAX) poll_cnt++;
					if (poll_cnt >= limit) begin
						poll_cnt = 4'd0;
						ack = ACK_MISSING;
					end
				end
			end else if (tick == 2'd1) begin
				tick = 2'd2;
			end else begin
				scl = 1'b0;
				tick = 2'd0;
				ack = ACK_SEEN;
			end
			if (ack == ACK_MISSING) begin
				state = ST_STOP_NACK;
				tick = 2'd0;
			end else if (ack == ACK_SEEN) begin
				case (state)
				ST_ACK_IDW: begin
					load_shift(lat_reg);
					state = ST_SEND_REG;
				end
				ST_ACK_REG: begin
					byte_idx = 8'd0;
					if (lat_read) begin
						tick = 2'd0;
						state = ST_RESTART;
					end else begin
						load_shift(8'd0);
						state = ST_SEND_DATA;
					end
				end
				ST_ACK_DATA: begin
					if (last_byte()) begin
						tick = 2'd0;
						state = ST_STOP;
					end else begin
						byte_idx++;
						load_shift(8'd0);
						state = ST_SEND_DATA;
					end
				end
				default: begin
					load_shift(8'd0);
					state = ST_RECV;
				end
				endcase
			end
		end
		ST_RESTART: begin
			if (tick == 2'd0) begin
				scl = 1'b0;
				tick = 2'd1;
			end else if (tick == 2'd1) begin
				tick = 2'd2;
			end else begin
				pull = 1'b1;
				load_shift({lat_id, 1'b1});
				state = ST_SEND_IDR;
			end
		end
		ST_RECV: begin
			if (tick == 2'd0) begin
				scl = 1'b0;
				tick = 2'd1;
			end else if (tick == 2'd1) begin
				shreg = {shreg[6:0], rq.sda_sample};
				tick = 2'd2;
			end else begin
				scl = 1'b0;
				tick = 2'd0;
				if (bit_idx >= LAST_BIT) begin
					bit_idx = 4'd0;
					rbyte = shreg;
					rvalid = 1'b1;
					state = ST_MASTER_ACK;
				end else begin
					bit_idx++;
				end
			end
		end
		ST_MASTER_ACK: begin
			// The master acknowledges every byte except the last one.
			pull = ~last_byte();
			if (tick == 2'd0) begin
				scl = 1'b0;
				tick = 2'd1;
			end else if (tick == 2'd1) begin
				tick = 2'd2;
			end else begin
				scl = 1'b0;
				tick = 2'd0;
				if (last_byte()) begin
					state = ST_STOP;
				end else begin
					byte_idx++;
					load_shift(8'd0);
					state = ST_RECV;
				end
			end
		end
		ST_STOP, ST_STOP_NACK: begin
			if (tick == 2'd0) begin
				scl = 1'b0;
				pull = 1'b1;
				tick = 2'd1;
			end else if (tick == 2'd1) begin
				pull = 1'b1;
				tick = 2'd2;
			end else begin
				done = 1'b1;
				nack = (state == ST_STOP_NACK);
				tick = 2'd0;
				state = ST_IDLE;
			end
		end
		default: begin
			state = ST_IDLE;
			tick = 2'd0;
			busy = 1'b0;
		end
		endcase
		r.scl_level = scl;
		r.sda_pull_low = pull;
		r.busy_res = busy;
		r.byte_position = byte_idx;
		r.read_byte = rbyte;
		r.read_valid = rvalid;
		r.done_res = done;
		r.nack_error = nack;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			state = ST_IDLE;
			tick = 2'd0;
			bit_idx = 4'd0;
			shreg = 8'd0;
			byte_idx = 8'd0;
			poll_cnt = 4'd0;
			lat_read = 1'b0;
			lat_id = 7'd0;
			lat_reg = 8'd0;
			lat_count = 8'd0;
			polls_cfg = ACK_POLLS_RESET;
			predicted_ticks.delete();
		end else begin
			if (cfg_we) polls_cfg = cfg_wdata;
			if (res_valid && res_ready) begin
				if (predicted_ticks.size() == 0) begin
					$error("result arrived with no request waiting for it");
					errors++;
				end else begin
					want = predicted_ticks.pop_front();
					check_field("scl_level", 8'(want.scl_level), 8'(res_data.scl_level));
					check_field("sda_pull_low", 8'(want.sda_pull_low),
						8'(res_data.sda_pull_low));
					check_field("busy_res", 8'(want.busy_res), 8'(res_data.busy_res));
					check_field("byte_position", want.byte_position, res_data.byte_position);
					check_field("read_byte", want.read_byte, res_data.read_byte);
					check_field("read_valid", 8'(want.read_valid), 8'(res_data.read_valid));
					check_field("done_res", 8'(want.done_res), 8'(res_data.done_res));
					check_field("nack_error", 8'(want.nack_error), 8'(res_data.nack_error));
				end
			end
			if (req_valid && req_ready) predicted_ticks.push_back(predict_bus_tick(req_data));
		end
		mismatch_count <= errors;
		pending_count <= predicted_ticks.size();
	end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Top of the I2C register master testbench: clock, reset, bus tick traffic that
// plays the target device, ack_polls writes and the verdict.
// Depends on i2crm_pkg, i2c_register_master_unit and i2crm_checker.
module testbench;
	import i2crm_pkg::*;

	typedef enum int {RX_STEADY, RX_CHOPPY, RX_SLUGGISH} sink_mode_e;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_t       req_data = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_t       res_data;
	logic       cfg_we = 1'b0;
	logic [3:0] cfg_wdata = 4'd0;
	int         mismatch_count;
	int         pending_count;

	logic [3:0] polls_now = ACK_POLLS_RESET;
	int         burst_left = 0;
	int         item_count = 0;

	i2c_register_master_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	i2crm_checker bus_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	// Offers one tick request, with a random gap before each new burst.
	task automatic send_tick(input req_t item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
		item_count++;
		req_valid <= 1'b1;
		req_data <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	function automatic req_t noise_item(input logic go, input logic sda);
		req_t r;
		r.start_request = go;
		r.read_not_write = 1'($urandom_range(0, 1));
		r.device_id = 7'($urandom_range(0, 127));
		r.register_address = 8'($urandom_range(0, 255));
		r.byte_count = 8'($urandom_range(0, 255));
		r.write_byte = 8'($urandom_range(0, 255));
		r.sda_sample = sda;
		return r;
	endfunction

	task automatic free_ticks(input int n);
		repeat (n) send_tick(noise_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
	endtask

	// Plays the target in one acknowledge slot: either holds SDA high until the
	// master gives up, or acknowledges after fewer high samples than that limit.
	task automatic ack_slot(input bit refuse, inout bit refused);
		int lim, d;
		lim = (polls_now == 4'd0) ? 1 : int'(polls_now);
		if (refuse) begin
			repeat (lim) send_tick(noise_item(1'($urandom_range(0, 1)), 1'b1));
			refused = 1'b1;
		end else begin
			d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim - 1) : 0;
			repeat (d) send_tick(noise_item(1'($urandom_range(0, 1)), 1'b1));
			send_tick(noise_item(1'($urandom_range(0, 1)), 1'b0));
			free_ticks(2);
		end
	endtask

	// One complete transaction; acknowledge slots are numbered from zero and
	// nack_slot names the one that is refused, if any.
	task automatic run_transfer(input bit rd, input logic [6:0] id, input logic [7:0] ra,
		input logic [7:0] cnt, input int nack_slot);
		req_t r;
		int   n, slot;
		bit   refused;
		n = (cnt == 8'd0) ? 1 : int'(cnt);
		slot = 0;
		refused = 1'b0;
		r = noise_item(1'b1, 1'($urandom_range(0, 1)));
		r.read_not_write = rd;
		r.device_id = id;
		r.register_address = ra;
		r.byte_count = cnt;
		send_tick(r);
		free_ticks(25);
		ack_slot(slot == nack_slot, refused);
		slot++;
		if (!refused) begin
			free_ticks(24);
			ack_slot(slot == nack_slot, refused);
			slot++;
		end
		if (!refused) begin
			if (rd) begin
				free_ticks(27);
				ack_slot(slot == nack_slot, refused);
				if (!refused) free_ticks(27 * n);
			end else begin
				for (int k = 0; k < n && !refused; k++) begin
					free_ticks(24);
					ack_slot(slot == nack_slot, refused);
					slot++;
				end
			end
		end
		free_ticks(3);
		repeat ($urandom_range(0, 2)) send_tick(noise_item(1'b0, 1'($urandom_range(0, 1))));
	endtask

	// A short transaction fed with a random SDA line; then SDA is held low,
	// which acknowledges everything, until the sequencer is surely idle again.
	task automatic garbled_transfer();
		req_t r;
		r = noise_item(1'b1, 1'($urandom_range(0, 1)));
		r.byte_count = 8'($urandom_range(0, 3));
		send_tick(r);
		repeat ($urandom_range(10, 120))
			send_tick(noise_item(1'b0, 1'($urandom_range(0, 1))));
		repeat (240) send_tick(noise_item(1'b0, 1'b0));
	endtask

	task automatic set_polls(input logic [3:0] v);
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		polls_now = v;
	endtask

	// Result side: changes its stall pattern now and then, and holds off for a
	// long stretch periodically so that the request side backs up.
	initial begin
		int         cyc, hold, mode_left;
		sink_mode_e mode;
		cyc = 0;
		hold = 0;
		mode_left = 0;
		mode = RX_STEADY;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 3000 == 1000) hold = 500;
			if (hold > 0) begin
				hold--;
				res_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = sink_mode_e'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 300);
				end
				mode_left--;
				case (mode)
				RX_STEADY: res_ready <= 1'b1;
				RX_CHOPPY: res_ready <= ($urandom_range(0, 1) == 1);
				default: res_ready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	initial begin
		int         xfers, waited, pick, n, slot;
		bit         rd;
		logic [7:0] cnt;
		logic [3:0] poll_set[5];
		poll_set = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd7};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_transfer(1'b0, 7'h00, 8'h00, 8'd1, -1);
		run_transfer(1'b0, 7'h7F, 8'hFF, 8'd2, -1);
		run_transfer(1'b1, 7'h2A, 8'h80, 8'd1, -1);
		run_transfer(1'b1, 7'h7F, 8'h00, 8'd3, -1);
		run_transfer(1'b0, 7'h11, 8'h22, 8'd0, -1);
		run_transfer(1'b1, 7'h33, 8'h44, 8'd0, -1);
		run_transfer(1'b0, 7'h50, 8'h01, 8'd4, 0);
		run_transfer(1'b1, 7'h50, 8'h02, 8'd2, 1);
		run_transfer(1'b0, 7'h05, 8'h03, 8'd3, 3);
		run_transfer(1'b1, 7'h05, 8'h04, 8'd2, 2);
		set_polls(4'd0);
		run_transfer(1'b0, 7'h6C, 8'h5A, 8'd2, 1);
		run_transfer(1'b1, 7'h13, 8'hA5, 8'd2, -1);
		set_polls(4'd15);
		run_transfer(1'b1, 7'h7F, 8'hFF, 8'd2, -1);
		run_transfer(1'b0, 7'h00, 8'h00, 8'd1, 0);
		set_polls(4'd1);
		run_transfer(1'b0, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 8'd255, 4);

		xfers = 0;
		while (item_count < 1550) begin
			if (xfers % 12 == 11) begin
				pick = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) :
					int'(poll_set[(xfers / 12) % 5]);
				set_polls(4'(pick));
			end
			if ($urandom_range(0, 19) == 0) begin
				garbled_transfer();
			end else begin
				rd = 1'($urandom_range(0, 1));
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					cnt = 8'd0;
				end else if (pick <= 2) begin
					cnt = 8'($urandom_range(5, 255));
				end else begin
					cnt = 8'($urandom_range(1, 4));
				end
				n = (cnt == 8'd0) ? 1 : int'(cnt);
				// Long byte counts are cut short by a refused acknowledge.
				if (n > 4) begin
					slot = $urandom_range(0, 2);
				end else if ($urandom_range(0, 9) == 0) begin
					slot = $urandom_range(0, rd ? 2 : n + 1);
				end else begin
					slot = -1;
				end
				run_transfer(rd, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
					cnt, slot);
			end
			xfers++;
		end

		req_valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (pending_count != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
